FILE: design/glyph_alpha_over_blend_core_defines.svh
// Assertion helpers for the glyph blend core.
`ifndef GLYPH_ALPHA_OVER_BLEND_CORE_DEFINES_SVH
`define GLYPH_ALPHA_OVER_BLEND_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define GAOB_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define GAOB_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/gaob_pkg.sv
package gaob_pkg;

  localparam logic [7:0] FULL = 8'd255;
  localparam logic [16:0] HALF = 17'd128;

  // config register indexes
  typedef enum logic [2:0] {
    REG_RED    = 3'd0,
    REG_GREEN  = 3'd1,
    REG_BLUE   = 3'd2,
    REG_TRANSP = 3'd3
  } cfg_reg_t;

  localparam int unsigned DIV_BITS   = 8;
  localparam int unsigned PRE_STAGES = 4;
  localparam int unsigned NUM_STAGES = PRE_STAGES + DIV_BITS + 1;

  // lane 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][7:0] pix_t;

  typedef struct packed {
    logic [15:0] prod;
    pix_t        dst;
  } s1_t;

  typedef struct packed {
    logic [7:0] k;
    pix_t       dst;
  } s2_t;

  typedef struct packed {
    logic [15:0] ka;
    logic [15:0] dab;
    pix_t        dst;
  } s3_t;

  typedef struct packed {
    logic [15:0]       w;
    logic [2:0][23:0]  src_term;
    logic [2:0][23:0]  dst_term;
    pix_t              dst;
  } s4_t;

  typedef struct packed {
    logic [15:0]       w;
    logic [2:0][23:0]  rem;
    logic [2:0][7:0]   quo;
    logic [7:0]        alpha;
    logic              zero;
    pix_t              dst;
  } dv_t;

  // rounded approximate divide by 255; x never exceeds 65025 here
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] q;
    logic [16:0] s;
    q = (17'(x) + HALF) >> 8;
    s = 17'(x) + q + HALF;
    return s[15:8];
  endfunction

endpackage

FILE: design/glyph_alpha_over_blend_core.sv
// Glyph alpha-over blend core.
// Input channel (in_valid/in_stall): one destination pixel and its glyph
// coverage per word. Output channel (out_valid/out_stall): the composited
// pixel. A word moves when valid is high and stall is low.
// Glyph color and transparency are written through cfg_we/cfg_index/
// cfg_data while the pipe is empty; unknown indexes are ignored.
// Throughput: one pixel per clock while the receiver does not stall. The
// pipe has 13 register stages (4 arithmetic stages:
// opacity product, source alpha, weight terms, channel products; then one
// sum stage and 8 restoring divide stages, one quotient bit each).
// Stalls: each stage advances when the one ahead is empty or moving, so
// bubbles collapse; in_stall rises only when every stage holds a pixel
// and the receiver stalls. Nothing is dropped or repeated.
// Reset (rst_n low, synchronous): pipe emptied, color and transparency
// cleared to zero.
`include "glyph_alpha_over_blend_core_defines.svh"

module glyph_alpha_over_blend_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_coverage,
  input  logic [7:0] in_dst_red,
  input  logic [7:0] in_dst_green,
  input  logic [7:0] in_dst_blue,
  input  logic [7:0] in_dst_alpha,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  localparam int unsigned NS   = gaob_pkg::NUM_STAGES;
  localparam int unsigned LAST = NS - 1;
  localparam int unsigned PRE  = gaob_pkg::PRE_STAGES;
  localparam int unsigned NDB  = gaob_pkg::DIV_BITS;

  logic [2:0][7:0] color_r;
  logic [7:0]      transp_r;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  logic          in_acc;
  logic          out_held;
  logic          out_live;
  logic [2:0]    rem_ok;

  gaob_pkg::s1_t s1_r, s1_nxt;
  gaob_pkg::s2_t s2_r, s2_nxt;
  gaob_pkg::s3_t s3_r, s3_nxt;
  gaob_pkg::s4_t s4_r, s4_nxt;
  gaob_pkg::dv_t dv_r   [NDB+1];
  gaob_pkg::dv_t dv_nxt [NDB+1];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r  <= '0;
      transp_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gaob_pkg::REG_RED:    color_r[0] <= cfg_data;
        gaob_pkg::REG_GREEN:  color_r[1] <= cfg_data;
        gaob_pkg::REG_BLUE:   color_r[2] <= cfg_data;
        gaob_pkg::REG_TRANSP: transp_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage i loads when it is empty or the stage ahead moves
  always_comb begin
    en[LAST] = !v_r[LAST] || !out_stall;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // coverage times opacity
  always_comb begin
    s1_nxt.prod = 16'(in_coverage) * 16'(gaob_pkg::FULL - transp_r);
    s1_nxt.dst  = {in_dst_alpha, in_dst_blue, in_dst_green, in_dst_red};
  end

  // source alpha
  always_comb begin
    s2_nxt.k   = gaob_pkg::div255(s1_r.prod);
    s2_nxt.dst = s1_r.dst;
  end

  // k*255 and dst_alpha*(255-k)
  always_comb begin
    s3_nxt.ka  = {s2_r.k, 8'd0} - 16'(s2_r.k);
    s3_nxt.dab = 16'(s2_r.dst[3]) * 16'(gaob_pkg::FULL - s2_r.k);
    s3_nxt.dst = s2_r.dst;
  end

  // weight and per-channel terms
  always_comb begin
    s4_nxt.w = s3_r.ka + s3_r.dab;
    for (int c = 0; c < 3; c++) begin
      s4_nxt.src_term[c] = 24'(s3_r.ka) * 24'(color_r[c]);
      s4_nxt.dst_term[c] = 24'(s3_r.dst[c]) * 24'(s3_r.dab);
    end
    s4_nxt.dst = s3_r.dst;
  end

  // numerators never exceed 255*w, so 24 bits hold the sum
  always_comb begin
    dv_nxt[0].w = s4_r.w;
    for (int c = 0; c < 3; c++) begin
      dv_nxt[0].rem[c] = s4_r.src_term[c] + s4_r.dst_term[c];
    end
    dv_nxt[0].quo   = '0;
    dv_nxt[0].alpha = gaob_pkg::div255(s4_r.w);
    dv_nxt[0].zero  = (s4_r.w == 16'd0);
    dv_nxt[0].dst   = s4_r.dst;
  end

  // restoring divide, MSB first, one quotient bit per stage
  for (genvar j = 1; j <= NDB; j++) begin : g_div
    localparam int unsigned B = NDB - j;
    always_comb begin
      logic [23:0] dvs;
      dvs       = 24'(dv_r[j-1].w) << B;
      dv_nxt[j] = dv_r[j-1];
      for (int c = 0; c < 3; c++) begin
        if (dv_r[j-1].rem[c] >= dvs) begin
          dv_nxt[j].rem[c]    = dv_r[j-1].rem[c] - dvs;
          dv_nxt[j].quo[c][B] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1_r <= s1_nxt;
    if (en[1]) s2_r <= s2_nxt;
    if (en[2]) s3_r <= s3_nxt;
    if (en[3]) s4_r <= s4_nxt;
    for (int j = 0; j <= NDB; j++) begin
      if (en[PRE+j]) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  // zero weight passes the destination pixel through
  assign out_red   = dv_r[NDB].zero ? dv_r[NDB].dst[0] : dv_r[NDB].quo[0];
  assign out_green = dv_r[NDB].zero ? dv_r[NDB].dst[1] : dv_r[NDB].quo[1];
  assign out_blue  = dv_r[NDB].zero ? dv_r[NDB].dst[2] : dv_r[NDB].quo[2];
  assign out_alpha = dv_r[NDB].zero ? dv_r[NDB].dst[3] : dv_r[NDB].alpha;

  assign in_acc    = in_valid && !in_stall;
  assign out_held  = out_valid && out_stall;
  assign out_live  = out_valid && !dv_r[NDB].zero;
  assign rem_ok[0] = dv_r[NDB].rem[0] < 24'(dv_r[NDB].w);
  assign rem_ok[1] = dv_r[NDB].rem[1] < 24'(dv_r[NDB].w);
  assign rem_ok[2] = dv_r[NDB].rem[2] < 24'(dv_r[NDB].w);

  `GAOB_ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, out_held, "in_stall without out_stall")
  `GAOB_ASSERT_NXT(a_accept_enters, clk, rst_n, in_acc, v_r[0], "accepted word lost")
  `GAOB_ASSERT_IMP(a_rem_below_w, clk, rst_n, out_live, &rem_ok, "remainder not below weight")
  `GAOB_ASSERT_IMP(a_alpha_nonzero, clk, rst_n, out_live, out_alpha != 8'd0, "alpha is zero")

endmodule

FILE: tb/sv/glyph_alpha_over_blend_core_tb.sv
module glyph_alpha_over_blend_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIPE_DEPTH       = 13;
  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam int unsigned PIXELS_PER_BLOCK = 150;
  localparam int unsigned BLOCKS_PER_PHASE = 3;
  localparam int unsigned OPAQUE           = 255;
  localparam int unsigned ROUND_BIAS       = 128;
  // indexes 4..7 decode to no register
  localparam logic [2:0]  REG_SPARE        = 3'd4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  class blend_scoreboard;
    logic [7:0]  glyph_red;
    logic [7:0]  glyph_green;
    logic [7:0]  glyph_blue;
    logic [7:0]  glyph_transp;
    rgba_t       blended_q[$];
    int unsigned errors;
    int unsigned accepted;
    int unsigned checked;

    function new();
      glyph_red    = '0;
      glyph_green  = '0;
      glyph_blue   = '0;
      glyph_transp = '0;
      errors       = 0;
      accepted     = 0;
      checked      = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        gaob_pkg::REG_RED:    glyph_red    = val;
        gaob_pkg::REG_GREEN:  glyph_green  = val;
        gaob_pkg::REG_BLUE:   glyph_blue   = val;
        gaob_pkg::REG_TRANSP: glyph_transp = val;
        default: ;
      endcase
    endfunction

    function int unsigned round_div255(int unsigned x);
      int unsigned q;
      q = (x + ROUND_BIAS) >> 8;
      return (x + q + ROUND_BIAS) >> 8;
    endfunction

    function logic [7:0] weighted_mean(int unsigned k, logic [7:0] src, logic [7:0] dst,
                                       logic [7:0] da, int unsigned w);
      int unsigned num;
      num = k * OPAQUE * int'(src) + int'(dst) * int'(da) * (OPAQUE - k);
      return 8'(num / w);
    endfunction

    function rgba_t blend(logic [7:0] cov, logic [7:0] dr, logic [7:0] dg,
                          logic [7:0] db, logic [7:0] da);
      int unsigned k;
      int unsigned w;
      rgba_t       px;
      k = round_div255(int'(cov) * (OPAQUE - int'(glyph_transp)));
      w = k * OPAQUE + int'(da) * (OPAQUE - k);
      // nothing to weigh: destination passes through untouched
      if (w == 0) begin
        px = '{red: dr, green: dg, blue: db, alpha: da};
      end else begin
        px.red   = weighted_mean(k, glyph_red, dr, da, w);
        px.green = weighted_mean(k, glyph_green, dg, da, w);
        px.blue  = weighted_mean(k, glyph_blue, db, da, w);
        px.alpha = 8'(round_div255(w));
      end
      return px;
    endfunction

    function void note_pixel(logic [7:0] cov, logic [7:0] dr, logic [7:0] dg,
                             logic [7:0] db, logic [7:0] da);
      blended_q.push_back(blend(cov, dr, dg, db, da));
      accepted++;
    endfunction

    function void check_pixel(rgba_t got);
      rgba_t want;
      if (blended_q.size() == 0) begin
        $error("output word %h with no pixel pending", got);
        errors++;
        return;
      end
      want = blended_q.pop_front();
      checked++;
      if (got.red !== want.red) begin
        $error("out_red: expected %0d, actual %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("out_green: expected %0d, actual %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("out_blue: expected %0d, actual %0d", want.blue, got.blue);
        errors++;
      end
      if (got.alpha !== want.alpha) begin
        $error("out_alpha: expected %0d, actual %0d", want.alpha, got.alpha);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return blended_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       cfg_we       = 1'b0;
  logic [2:0] cfg_index    = '0;
  logic [7:0] cfg_data     = '0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_coverage  = '0;
  logic [7:0] in_dst_red   = '0;
  logic [7:0] in_dst_green = '0;
  logic [7:0] in_dst_blue  = '0;
  logic [7:0] in_dst_alpha = '0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned glyph_settings = 0;

  blend_scoreboard sb = new();

  glyph_alpha_over_blend_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_coverage (in_coverage),
    .in_dst_red  (in_dst_red),
    .in_dst_green(in_dst_green),
    .in_dst_blue (in_dst_blue),
    .in_dst_alpha(in_dst_alpha),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_pixel(in_coverage, in_dst_red, in_dst_green, in_dst_blue, in_dst_alpha);
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      sb.check_pixel('{red: out_red, green: out_green, blue: out_blue, alpha: out_alpha});
    end
  end

  // extremes show up often enough to hit zero-weight and full-cover paths
  function automatic logic [7:0] skewed_byte();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] cov, input logic [7:0] dr,
                            input logic [7:0] dg, input logic [7:0] db,
                            input logic [7:0] da);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_coverage  <= cov;
    in_dst_red   <= dr;
    in_dst_green <= dg;
    in_dst_blue  <= db;
    in_dst_alpha <= da;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_pixel();
    send_pixel(skewed_byte(), 8'($urandom), 8'($urandom), 8'($urandom), skewed_byte());
  endtask

  // hold input until the pipe has delivered every pending word
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_glyph(input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] t);
    write_reg(gaob_pkg::REG_RED, r);
    write_reg(gaob_pkg::REG_GREEN, g);
    write_reg(gaob_pkg::REG_BLUE, b);
    write_reg(gaob_pkg::REG_TRANSP, t);
    // a stray index must leave the color alone
    write_reg(REG_SPARE + 3'($urandom_range(3)), 8'($urandom));
    cfg_we <= 1'b0;
    glyph_settings++;
  endtask

  initial begin
    int unsigned blk;
    blk = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // opaque glyph
    set_glyph(8'd255, 8'd0, 8'd128, 8'd0);
    send_pixel(8'd0, 8'h5a, 8'ha5, 8'hff, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd255, 8'd255, 8'd255, 8'd1);
    send_pixel(8'd254, 8'd0, 8'd255, 8'd0, 8'd254);
    drain();
    // fully transparent glyph
    set_glyph(8'd0, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd1, 8'd2, 8'd3, 8'd0);
    send_pixel(8'd255, 8'd200, 8'd100, 8'd50, 8'd200);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    drain();
    set_glyph(8'd17, 8'd200, 8'd99, 8'd128);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0);
    send_pixel(8'd100, 8'd30, 8'd60, 8'd90, 8'd77);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd3, 8'd170, 8'd85, 8'd240, 8'd15);

    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          send_idle_pct  = 32;
          recv_stall_pct = 68;
        end
        1: begin
          send_idle_pct  = 68;
          recv_stall_pct = 32;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
        if (b != 0) drain();
        case (blk)
          0:       set_glyph(8'd255, 8'd255, 8'd255, 8'd0);
          1:       set_glyph(8'd0, 8'd0, 8'd0, 8'd255);
          default: set_glyph(8'($urandom), 8'($urandom), 8'($urandom), skewed_byte());
        endcase
        blk++;
        repeat (PIXELS_PER_BLOCK) random_pixel();
      end
    end

    drain();
    $display("Blended %0d pixels, %0d checked, over %0d glyph color settings;",
             sb.accepted, sb.checked, glyph_settings);
    $display("sender/receiver idle rates 32/68, 68/32 and 0/0 percent.");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
